// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files that check themselves (the top level uses them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ifmt_pkg.sv =====
// Shared types, constants and helpers of the integer to ASCII formatter.
`timescale 1ns / 1ps

package ifmt_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int VALUE_BITS_MAX = 64;
    // counts cover the whole VALUE_BITS range
    localparam int CNT_W = $clog2(VALUE_BITS_MAX + 1);
    localparam int DIG_W = 6;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;

    localparam logic [5:0] RADIX_RST = 6'd10;
    localparam logic [5:0] FW_RST    = 6'd0;
    localparam logic [7:0] PAD_RST   = 8'h20;
    localparam logic [7:0] PLUS_RST  = 8'h00;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;

    typedef enum logic [1:0] {
        REG_RADIX,
        REG_FIELD_WIDTH,
        REG_PAD_CHAR,
        REG_PLUS_CHAR
    } t_reg_idx;

    // job descriptor handed from the converter to the emitter
    typedef struct packed {
        logic             sign_en;
        logic [7:0]       sign_char;
        logic [7:0]       pad_char;
        logic             hash;
        logic [CNT_W-1:0] pad_cnt;
        logic [CNT_W-1:0] nd;
    } t_hdr;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
        logic [7:0] d8;
        d8 = {2'b00, d};
        return (d > 6'd9) ? (d8 - 8'd10 + CH_A) : (d8 + CH_ZERO);
    endfunction

endpackage

// ===== src/ifmt_queue.sv =====
// Two-entry job queue between the converter and the character emitter.
`timescale 1ns / 1ps

module ifmt_queue import ifmt_pkg::*; #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  logic [DW-1:0] i_wr_data,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output logic [DW-1:0] o_rd_data
);

    localparam int Q_DEPTH = 2;

    logic [DW-1:0] r_mem [Q_DEPTH];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/ifmt_front.sv =====
// Front end: takes a value, shifts its magnitude bit by bit into a radix digit row.
`timescale 1ns / 1ps

module ifmt_front import ifmt_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [VALUE_BITS-1:0]       i_number,
    input  logic                        i_signed,
    input  logic [5:0]                  i_radix,
    input  logic [5:0]                  i_field_width,
    input  logic [7:0]                  i_pad_char,
    input  logic [7:0]                  i_plus_char,
    output logic                        o_valid,
    input  logic                        i_ready,
    output t_hdr                        o_hdr,
    output logic [VALUE_BITS*DIG_W-1:0] o_digits
);

    localparam int CW  = $clog2(VALUE_BITS + 1);
    localparam int BCW = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {F_IDLE, F_CONV, F_DONE} t_fstate;

    t_fstate                              r_state;
    logic [VALUE_BITS-1:0]                r_mag;
    logic                                 r_neg;
    logic                                 r_sgn;
    logic [5:0]                           r_base;
    logic [VALUE_BITS-1:0][DIG_W-1:0]     r_dig;
    logic [CW-1:0]                        r_nd;
    logic [BCW-1:0]                       r_bit;

    logic [VALUE_BITS-1:0]                w_g;
    logic [VALUE_BITS-1:0]                w_p;
    logic [VALUE_BITS:0]                  w_sum;
    logic [VALUE_BITS:0]                  w_carry;
    logic [VALUE_BITS-1:0][DIG_W-1:0]     n_dig;
    logic [CW-1:0]                        n_nd;
    logic [6:0]                           w_base7;
    logic [6:0]                           w_t [VALUE_BITS];
    logic                                 w_neg;
    logic [VALUE_BITS-1:0]                w_neg_mag;
    logic [5:0]                           w_base_clamp;
    logic [CNT_W-1:0]                     w_fw;
    logic [CNT_W-1:0]                     w_width;
    logic [CNT_W-1:0]                     w_nd_ext;
    logic                                 w_pad_en;
    logic                                 w_hash;

    assign o_ready  = (r_state == F_IDLE);
    assign o_valid  = (r_state == F_DONE);
    assign o_digits = r_dig;

    assign w_neg     = i_signed && i_number[VALUE_BITS-1];
    assign w_neg_mag = ~i_number + {{(VALUE_BITS-1){1'b0}}, 1'b1};
    assign w_base_clamp = (i_radix < RADIX_MIN) ? RADIX_MIN :
                          (i_radix > RADIX_MAX) ? RADIX_MAX : i_radix;

    // Each digit cell does d = 2d + cin mod base. The carry ripple is
    // generate/propagate, so one adder resolves all cell carries at once.
    assign w_base7 = {1'b0, r_base};

    always_comb begin
        for (int k = 0; k < VALUE_BITS; k++) begin
            w_g[k] = ({r_dig[k], 1'b0} >= w_base7);
            w_p[k] = ({r_dig[k], 1'b1} == w_base7);
        end
    end

    assign w_sum   = {1'b0, w_g | w_p} + {1'b0, w_g}
                   + {{VALUE_BITS{1'b0}}, r_mag[VALUE_BITS-1]};
    assign w_carry = w_sum ^ {1'b0, w_g | w_p} ^ {1'b0, w_g};

    always_comb begin
        for (int k = 0; k < VALUE_BITS; k++) begin
            w_t[k]   = {r_dig[k], w_carry[k]} - (w_carry[k+1] ? w_base7 : 7'd0);
            n_dig[k] = w_t[k][DIG_W-1:0];
        end
    end

    // cells above the top digit are zero, so only the top one can grow the count
    assign n_nd = r_nd + CW'(w_carry[r_nd]);

    // descriptor
    assign w_fw     = CNT_W'(i_field_width);
    assign w_width  = (w_fw > CNT_W'(VALUE_BITS)) ? CNT_W'(VALUE_BITS) : w_fw;
    assign w_nd_ext = CNT_W'(r_nd);
    assign w_pad_en = (i_pad_char != 8'd0) && (w_width != '0);
    assign w_hash   = w_pad_en && (w_nd_ext > w_width);

    always_comb begin
        o_hdr.sign_en   = r_sgn && (r_neg || (i_plus_char != 8'd0));
        o_hdr.sign_char = r_neg ? CH_MINUS : i_plus_char;
        o_hdr.pad_char  = i_pad_char;
        o_hdr.hash      = w_hash;
        o_hdr.pad_cnt   = (w_pad_en && !w_hash) ? (w_width - w_nd_ext) : '0;
        o_hdr.nd        = w_nd_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_mag   <= w_neg ? w_neg_mag : i_number;
                        r_neg   <= w_neg;
                        r_sgn   <= i_signed;
                        r_base  <= w_base_clamp;
                        r_dig   <= '0;
                        r_nd    <= CW'(1);
                        r_bit   <= BCW'(VALUE_BITS - 1);
                        r_state <= F_CONV;
                    end
                end
                F_CONV: begin
                    r_dig <= n_dig;
                    r_nd  <= n_nd;
                    r_mag <= {r_mag[VALUE_BITS-2:0], 1'b0};
                    if (r_bit == '0) begin
                        r_state <= F_DONE;
                    end else begin
                        r_bit <= r_bit - BCW'(1);
                    end
                end
                F_DONE: begin
                    if (i_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== src/ifmt_back.sv =====
// Back end: walks a job descriptor and sends sign, padding and digit characters.
`timescale 1ns / 1ps

module ifmt_back import ifmt_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_hdr                        i_hdr,
    input  logic [VALUE_BITS*DIG_W-1:0] i_digits,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [7:0]                  o_m_char,
    output logic                        o_m_last
);

    localparam int IW = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {B_IDLE, B_SIGN, B_PAD, B_DIG} t_bstate;

    t_bstate                          r_state;
    t_hdr                             r_hdr;
    logic [VALUE_BITS-1:0][DIG_W-1:0] r_dig;
    logic [CNT_W-1:0]                 r_pad;
    logic [CNT_W-1:0]                 r_idx;
    logic                             r_valid;
    logic [7:0]                       r_char;
    logic                             r_last;

    logic                             w_can_emit;
    logic                             w_emit;
    logic [CNT_W-1:0]                 w_idx_m1;
    logic [IW-1:0]                    w_sel;
    logic [7:0]                       w_dchar;

    assign o_ready    = (r_state == B_IDLE);
    assign o_m_valid  = r_valid;
    assign o_m_char   = r_char;
    assign o_m_last   = r_last;
    assign w_can_emit = !r_valid || i_m_ready;
    // every busy state puts out one word whenever the output register frees up
    assign w_emit     = (r_state != B_IDLE) && w_can_emit;

    // digits go out most significant first
    assign w_idx_m1 = r_idx - CNT_W'(1);
    assign w_sel    = w_idx_m1[IW-1:0];
    assign w_dchar  = r_hdr.hash ? CH_HASH : digit_char(r_dig[w_sel]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_hdr <= i_hdr;
                        r_dig <= i_digits;
                        r_pad <= i_hdr.pad_cnt;
                        r_idx <= i_hdr.nd;
                        if (i_hdr.sign_en) begin
                            r_state <= B_SIGN;
                        end else if (i_hdr.pad_cnt != '0) begin
                            r_state <= B_PAD;
                        end else begin
                            r_state <= B_DIG;
                        end
                    end
                end
                B_SIGN: begin
                    if (w_can_emit) begin
                        r_char  <= r_hdr.sign_char;
                        r_last  <= 1'b0;
                        r_state <= (r_pad != '0) ? B_PAD : B_DIG;
                    end
                end
                B_PAD: begin
                    if (w_can_emit) begin
                        r_char  <= r_hdr.pad_char;
                        r_last  <= 1'b0;
                        r_pad   <= r_pad - CNT_W'(1);
                        if (r_pad == CNT_W'(1)) begin
                            r_state <= B_DIG;
                        end
                    end
                end
                B_DIG: begin
                    if (w_can_emit) begin
                        r_char  <= w_dchar;
                        r_last  <= (r_idx == CNT_W'(1));
                        r_idx   <= w_idx_m1;
                        if (r_idx == CNT_W'(1)) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== src/integer_to_ascii_formatter_unit.sv =====
// Top level of the integer to ASCII formatter: config registers, front, queue, back.
//
// Usage:
//  - Input stream (s_axis_*): one word per value; tdata holds the value,
//    tuser selects unsigned (0) or two's complement signed (1) conversion.
//  - Output stream (m_axis_*): one word per character, most significant
//    digit first; tlast marks the final character of each value.
//  - Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//    (0 radix, 1 field width, 2 pad char, 3 plus char). Write only while idle.
//  - Conversion: the converter shifts the magnitude into the digit row,
//    one shift per cycle. The emitter loads a job from the queue, then
//    sends one character per cycle while the receiver keeps tready high.
//    m_axis_tvalid first rises once the first character is registered.
//  - A two-entry job queue sits between converter and emitter, so a new
//    value is taken while the previous one's characters still drain.
//  - Reset (synchronous, active low) empties the queue, drops any pending
//    character and restores radix 10, width 0, pad ' ', no plus char.
//  - When the receiver holds tready low the output word holds, the emitter
//    stops, the queue fills, and then s_axis_tready stays low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_to_ascii_formatter_unit import ifmt_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [VALUE_BITS-1:0] number
    input  logic                                s_axis_tuser,  // [0] cmd
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [7:0] out_char
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [7:0]                          i_cfg_data
);

    localparam int DIGW = VALUE_BITS * DIG_W;
    localparam int HDRW = $bits(t_hdr);
    localparam int QW   = HDRW + DIGW;

    logic [5:0]       r_radix;
    logic [5:0]       r_field_width;
    logic [7:0]       r_pad_char;
    logic [7:0]       r_plus_char;

    logic             w_push_valid;
    logic             w_push_ready;
    t_hdr             w_front_hdr;
    logic [DIGW-1:0]  w_front_dig;
    logic             w_pop_valid;
    logic             w_pop_ready;
    logic [QW-1:0]    w_q_out;
    t_hdr             w_back_hdr;
    logic [DIGW-1:0]  w_back_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= RADIX_RST;
            r_field_width <= FW_RST;
            r_pad_char    <= PAD_RST;
            r_plus_char   <= PLUS_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RADIX:       r_radix       <= i_cfg_data[5:0];
                REG_FIELD_WIDTH: r_field_width <= i_cfg_data[5:0];
                REG_PAD_CHAR:    r_pad_char    <= i_cfg_data;
                REG_PLUS_CHAR:   r_plus_char   <= i_cfg_data;
                default:         r_radix       <= r_radix;
            endcase
        end
    end

    ifmt_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_number      (s_axis_tdata[VALUE_BITS-1:0]),
        .i_signed      (s_axis_tuser),
        .i_radix       (r_radix),
        .i_field_width (r_field_width),
        .i_pad_char    (r_pad_char),
        .i_plus_char   (r_plus_char),
        .o_valid       (w_push_valid),
        .i_ready       (w_push_ready),
        .o_hdr         (w_front_hdr),
        .o_digits      (w_front_dig)
    );

    ifmt_queue #(
        .DW (QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_data  ({w_front_hdr, w_front_dig}),
        .o_rd_valid (w_pop_valid),
        .i_rd_ready (w_pop_ready),
        .o_rd_data  (w_q_out)
    );

    assign w_back_hdr = w_q_out[QW-1:DIGW];
    assign w_back_dig = w_q_out[DIGW-1:0];

    ifmt_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_pop_valid),
        .o_ready   (w_pop_ready),
        .i_hdr     (w_back_hdr),
        .i_digits  (w_back_dig),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_char  (m_axis_tdata),
        .o_m_last  (m_axis_tlast)
    );

    // converter is busy right after it takes a value
    `ASSERT_NEXT(a_front_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "front took a word while busy")
    // handing a job to the queue frees the converter
    `ASSERT_NEXT(a_front_free, i_clk, i_rst_n, w_push_valid && w_push_ready, s_axis_tready, "front not free after push")
    // emitter loads one job and works on it before the next
    `ASSERT_NEXT(a_back_busy, i_clk, i_rst_n, w_pop_valid && w_pop_ready, !w_pop_ready, "back popped two jobs in a row")

endmodule
